// ===== rtl/core/m3i_pkg.sv =====
// shared widths, beat types and product index tables for the 3x3 matrix inverse
`default_nettype none
package m3i_pkg;
	localparam int IN_WIDTH  = 16;
	localparam int OUT_WIDTH = 24;
	localparam int IN_FRAC   = IN_WIDTH - 4;
	localparam int OUT_FRAC  = OUT_WIDTH - 8;
	localparam int NUM_ELEM  = 9;
	localparam int NUM_PROD  = 18;

	// operand pairs of the cofactor products, element order r0c0..r2c2
	localparam int PROD_A [NUM_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
	localparam int PROD_B [NUM_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] m_r0c0;
		logic signed [IN_WIDTH-1:0] m_r0c1;
		logic signed [IN_WIDTH-1:0] m_r0c2;
		logic signed [IN_WIDTH-1:0] m_r1c0;
		logic signed [IN_WIDTH-1:0] m_r1c1;
		logic signed [IN_WIDTH-1:0] m_r1c2;
		logic signed [IN_WIDTH-1:0] m_r2c0;
		logic signed [IN_WIDTH-1:0] m_r2c1;
		logic signed [IN_WIDTH-1:0] m_r2c2;
	} mat_beat_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] inv_r0c0;
		logic signed [OUT_WIDTH-1:0] inv_r0c1;
		logic signed [OUT_WIDTH-1:0] inv_r0c2;
		logic signed [OUT_WIDTH-1:0] inv_r1c0;
		logic signed [OUT_WIDTH-1:0] inv_r1c1;
		logic signed [OUT_WIDTH-1:0] inv_r1c2;
		logic signed [OUT_WIDTH-1:0] inv_r2c0;
		logic signed [OUT_WIDTH-1:0] inv_r2c1;
		logic signed [OUT_WIDTH-1:0] inv_r2c2;
		logic                        singular;
	} inv_beat_t;
endpackage
`default_nettype wire

// ===== rtl/core/m3i_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow detect
`default_nettype none
module m3i_div_pipe #(
	parameter int NW = 60,
	parameter int DW = 48,
	parameter int QW = 24,
	parameter int SW = 26
) (
	input  wire logic          clk,
	input  wire logic [QW:0]   en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic      [QW-1:0] quot,
	output logic               ovf,
	output logic      [SW-1:0] side_out
);
	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [CW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] q_s    [QW+1];
	logic [QW:0]   ovf_s;
	logic [SW-1:0] side_s [QW+1];
	logic [CW-1:0] sh     [QW];
	logic [QW:0]   take;

	always_comb begin
		take = '0;
		for (int j = 1; j <= QW; j++) begin
			sh[j-1] = CW'(den_s[j-1]) << (QW - j);
			take[j] = !ovf_s[j-1] && (rem_s[j-1] >= sh[j-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= CW'(num);
			den_s[0]  <= den;
			q_s[0]    <= '0;
			ovf_s[0]  <= CW'(num) >= (CW'(den) << QW);
			side_s[0] <= side;
		end
		for (int j = 1; j <= QW; j++) begin
			if (en[j]) begin
				rem_s[j]  <= take[j] ? rem_s[j-1] - sh[j-1] : rem_s[j-1];
				q_s[j]    <= q_s[j-1] | (take[j] ? (QW'(1) << (QW - j)) : QW'(0));
				den_s[j]  <= den_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign quot     = q_s[QW];
	assign ovf      = ovf_s[QW];
	assign side_out = side_s[QW];
endmodule
`default_nettype wire

// ===== rtl/core/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by adjugate and determinant, fully pipelined
// usage:
//   mat channel: one beat carries a whole 3x3 matrix of signed Q4.12 elements,
//   taken at a clock edge with mat_valid high and mat_stall low
//   inv channel: one beat carries the nine signed Q8.16 inverse elements and
//   the singular flag, taken with inv_valid high and inv_stall low
//   throughput is one matrix per cycle while inv_stall is low; five stages form
//   products, cofactors and the determinant, then nine dividers resolve one quotient bit per stage
//   quotients truncate toward zero and saturate; a zero determinant passes the
//   input matrix through, widened, with singular set
//   each stage holds its own valid bit, so bubbles close up while the output is
//   stalled and mat_stall rises only once every stage holds a beat
//   arst_n clears all valid bits; nothing is in flight after reset
`default_nettype none
module matrix3x3_inverse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              mat_valid,
	output logic                   mat_stall,
	input  wire m3i_pkg::mat_beat_t mat,
	output logic                   inv_valid,
	input  wire logic              inv_stall,
	output m3i_pkg::inv_beat_t     inv
);
	import m3i_pkg::*;

	localparam int W   = IN_WIDTH;
	localparam int QW  = OUT_WIDTH;
	localparam int S   = IN_FRAC + OUT_FRAC;
	localparam int PW  = 2 * W;
	localparam int CFW = 2 * W + 1;
	localparam int DPW = 3 * W + 1;
	localparam int DTW = 3 * W + 3;
	localparam int DW  = 3 * W;
	localparam int NW  = 2 * W + S;
	localparam int XW  = W + QW + 1;
	localparam int SH  = OUT_FRAC - IN_FRAC;
	localparam int SHA = (SH >= 0) ? SH : -SH;
	localparam int NPRE = 5;
	localparam int NST  = NPRE + QW + 2;
	localparam int SW   = QW + 2;

	function automatic logic [QW-1:0] widen(input logic signed [W-1:0] v);
		logic              neg;
		logic signed [W:0] vx;
		logic [XW-1:0]     m;
		logic [XW-1:0]     lim;
		neg = v[W-1];
		vx  = {v[W-1], v};
		m   = XW'(unsigned'(neg ? -vx : vx));
		if (SH >= 0) m = m << SHA;
		else m = m >> SHA;
		lim = neg ? (XW'(1) << (QW - 1)) : (XW'(1) << (QW - 1)) - XW'(1);
		if (m > lim) m = lim;
		widen = neg ? QW'(-m) : QW'(m);
	endfunction

	logic [NST:0]   en;
	logic [NST-1:0] vld_q;

	logic signed [W-1:0]   m_in   [NUM_ELEM];
	logic signed [PW-1:0]  prod_s1 [NUM_PROD];
	logic signed [W-1:0]   abc_s1 [3];
	logic [QW-1:0]         wide_s1 [NUM_ELEM];
	logic signed [CFW-1:0] cof_s2 [NUM_ELEM];
	logic signed [W-1:0]   abc_s2 [3];
	logic [QW-1:0]         wide_s2 [NUM_ELEM];
	logic signed [DPW-1:0] dp_s3  [3];
	logic signed [CFW-1:0] cof_s3 [NUM_ELEM];
	logic [QW-1:0]         wide_s3 [NUM_ELEM];
	logic signed [DTW-1:0] det_s4;
	logic signed [CFW-1:0] cof_s4 [NUM_ELEM];
	logic [QW-1:0]         wide_s4 [NUM_ELEM];
	logic [DW-1:0]         dmag_s5;
	logic                  sing_s5;
	logic [PW-1:0]         cmag_s5 [NUM_ELEM];
	logic [NUM_ELEM-1:0]   neg_s5;
	logic [QW-1:0]         wide_s5 [NUM_ELEM];
	logic [QW-1:0]         quot   [NUM_ELEM];
	logic [NUM_ELEM-1:0]   ovf;
	logic [SW-1:0]         side_o [NUM_ELEM];
	logic [QW-1:0]         res    [NUM_ELEM];
	logic [QW-1:0]         fin_s  [NUM_ELEM];
	logic                  sing_fin_s;

	assign m_in[0] = mat.m_r0c0;
	assign m_in[1] = mat.m_r0c1;
	assign m_in[2] = mat.m_r0c2;
	assign m_in[3] = mat.m_r1c0;
	assign m_in[4] = mat.m_r1c1;
	assign m_in[5] = mat.m_r1c2;
	assign m_in[6] = mat.m_r2c0;
	assign m_in[7] = mat.m_r2c1;
	assign m_in[8] = mat.m_r2c2;

	// a stage loads when empty or when the next one moves on
	always_comb begin
		en[NST] = !inv_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign mat_stall = !en[0];
	assign inv_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= mat_valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// products and widened copies
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < NUM_PROD; j++) begin
				prod_s1[j] <= PW'(m_in[PROD_A[j]]) * PW'(m_in[PROD_B[j]]);
			end
			for (int k = 0; k < 3; k++) abc_s1[k] <= m_in[k];
			for (int k = 0; k < NUM_ELEM; k++) wide_s1[k] <= widen(m_in[k]);
		end
	end

	// cofactors
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < NUM_ELEM; k++) begin
				cof_s2[k]  <= CFW'(prod_s1[2*k]) - CFW'(prod_s1[2*k+1]);
				wide_s2[k] <= wide_s1[k];
			end
			abc_s2 <= abc_s1;
		end
	end

	// determinant terms along the first row
	always_ff @(posedge clk) begin
		if (en[2]) begin
			dp_s3[0] <= DPW'(abc_s2[0]) * DPW'(cof_s2[0]);
			dp_s3[1] <= DPW'(abc_s2[1]) * DPW'(cof_s2[3]);
			dp_s3[2] <= DPW'(abc_s2[2]) * DPW'(cof_s2[6]);
			cof_s3   <= cof_s2;
			wide_s3  <= wide_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			det_s4  <= DTW'(dp_s3[0]) + DTW'(dp_s3[1]) + DTW'(dp_s3[2]);
			cof_s4  <= cof_s3;
			wide_s4 <= wide_s3;
		end
	end

	// magnitudes and quotient signs
	always_ff @(posedge clk) begin
		if (en[4]) begin
			dmag_s5 <= DW'(unsigned'(det_s4[DTW-1] ? -det_s4 : det_s4));
			sing_s5 <= (det_s4 == '0);
			for (int k = 0; k < NUM_ELEM; k++) begin
				cmag_s5[k] <= PW'(unsigned'(cof_s4[k][CFW-1] ? -cof_s4[k] : cof_s4[k]));
				neg_s5[k]  <= cof_s4[k][CFW-1] ^ det_s4[DTW-1];
				wide_s5[k] <= wide_s4[k];
			end
		end
	end

	for (genvar k = 0; k < NUM_ELEM; k++) begin : g_div
		m3i_div_pipe #(
			.NW (NW),
			.DW (DW),
			.QW (QW),
			.SW (SW)
		) u_div (
			.clk      (clk),
			.en       (en[NPRE +: QW + 1]),
			.num      ({cmag_s5[k], {S{1'b0}}}),
			.den      (dmag_s5),
			.side     ({sing_s5, neg_s5[k], wide_s5[k]}),
			.quot     (quot[k]),
			.ovf      (ovf[k]),
			.side_out (side_o[k])
		);
	end

	// saturate, restore sign, pick the pass-through on a singular matrix
	always_comb begin
		for (int k = 0; k < NUM_ELEM; k++) begin
			logic          neg;
			logic [QW-1:0] lim;
			logic [QW-1:0] q;
			neg = side_o[k][QW];
			lim = neg ? (QW'(1) << (QW - 1)) : (QW'(1) << (QW - 1)) - QW'(1);
			q   = (ovf[k] || quot[k] > lim) ? lim : quot[k];
			res[k] = side_o[k][QW+1] ? side_o[k][QW-1:0] : (neg ? -q : q);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			fin_s      <= res;
			sing_fin_s <= side_o[0][QW+1];
		end
	end

	assign inv.inv_r0c0 = fin_s[0];
	assign inv.inv_r0c1 = fin_s[1];
	assign inv.inv_r0c2 = fin_s[2];
	assign inv.inv_r1c0 = fin_s[3];
	assign inv.inv_r1c1 = fin_s[4];
	assign inv.inv_r1c2 = fin_s[5];
	assign inv.inv_r2c0 = fin_s[6];
	assign inv.inv_r2c1 = fin_s[7];
	assign inv.inv_r2c2 = fin_s[8];
	assign inv.singular = sing_fin_s;
endmodule
`default_nettype wire
